// ----- rtl/core/ipte_pkg.sv -----
package ipte_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLOT_RD,
    ST_SLOT,
    ST_CHECK,
    ST_NODE,
    ST_DEC,
    ST_WR_B,
    ST_WR_N,
    ST_WR_PAR,
    ST_WR_ASN,
    ST_RES,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    STS_NEW      = 3'd0,
    STS_REPLACED = 3'd1,
    STS_REJECTED = 3'd2,
    STS_FULL     = 3'd3,
    STS_MATCH    = 3'd4,
    STS_NO_MATCH = 3'd5
  } status_t;

  localparam logic       REQ_INSERT = 1'b0;
  localparam logic       REQ_LOOKUP = 1'b1;
  localparam logic [4:0] LEN_MIN    = 5'd8;
  localparam logic [4:0] LEN_MAX    = 5'd24;

  function automatic logic [31:0] keep_top(input logic [31:0] a, input logic [4:0] len);
    logic [31:0] m;
    m = (len == 5'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - {1'b0, len}));
    return a & m;
  endfunction

  function automatic logic bit_at(input logic [31:0] a, input logic [4:0] pos);
    return a[5'd31 - pos];
  endfunction

  function automatic logic [15:0] link_of(input logic [31:0] links, input logic dir);
    return dir ? links[31:16] : links[15:0];
  endfunction

  function automatic logic [31:0] link_set(input logic [31:0] links, input logic dir,
                                           input logic [15:0] v);
    return dir ? {v, links[15:0]} : {links[31:16], v};
  endfunction

endpackage

// ----- rtl/core/ipte_ram.sv -----
module ipte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/ipte_lcp.sv -----
module ipte_lcp (
  input  logic [31:0] diff,
  output logic [5:0]  lead
);

  logic [3:0] bz [4];

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      bz[b] = 4'd8;
      for (int i = 0; i < 8; i++) begin
        if (diff[b*8 + i]) begin
          bz[b] = 4'(7 - i);
        end
      end
    end
  end

  always_comb begin
    priority if (bz[3] != 4'd8) begin
      lead = {2'b00, bz[3]};
    end else if (bz[2] != 4'd8) begin
      lead = 6'd8 + {2'b00, bz[2]};
    end else if (bz[1] != 4'd8) begin
      lead = 6'd16 + {2'b00, bz[1]};
    end else begin
      lead = 6'd24 + {2'b00, bz[0]};
    end
  end

endmodule

// ----- rtl/core/ipv4_prefix_trie_engine.sv -----
// IPv4 prefix-to-ASN table with longest-prefix lookup.
// Input channel (in_valid/in_ready): one request, either an insert of a
// route (address, prefix_len 8..24, route_asn, stamp) or a lookup of an address.
// Output channel (out_valid/out_ready): one result per insert; one result per
// matching prefix for a lookup, shortest first, or a single no-match result.
// The last result of each request carries last = 1.
// A request reads its root slot and then walks the trie, each node taking
// one node RAM read, one prefix compare and one decision; at most
// 16 nodes are walked. An insert that adds nodes then writes a branch node
// (on a split), the new node and the parent link. The single-port node RAM
// and the shared prefix-compare unit set the pace of a request.
// in_ready is high only while idle. Results go through an output register; a
// stalled receiver holds the sequencer until the pending result is taken.
// Reset clears the root slots (per-slot valid bits), node count and route
// count at once; the node pool needs no clearing pass.
module ipv4_prefix_trie_engine #(
  parameter int POOL_NODES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [31:0] address,
  input  logic [4:0]  prefix_len,
  input  logic [31:0] route_asn,
  input  logic [31:0] stamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [4:0]  match_len,
  output logic [31:0] match_asn,
  output logic [31:0] match_stamp,
  output logic [16:0] route_count,
  output logic        last
);

  localparam int          NW       = $clog2(POOL_NODES);
  localparam logic [16:0] POOL_LIM = 17'(POOL_NODES);

  ipte_pkg::state_t state, state_next;

  logic        req_q;
  logic [31:0] a_q, asn_q, stamp_q;
  logic [4:0]  len_q;
  logic [15:0] idx_q, par_idx_q, child_q, nodes_used;
  logic        dir_q, par_root_q, split_q, above_q;
  logic [127:0] par_q, cur_q;
  logic [5:0]  lcp_q;
  logic [4:0]  common_q;
  logic [16:0] routes;
  logic [255:0] slot_vld;
  logic        pend_v;
  logic [4:0]  pend_len;
  logic [31:0] pend_asn, pend_stamp;
  logic [2:0]  res_q;

  logic         slot_we, node_we;
  logic [95:0]  slot_wdata, slot_rdata, slot_rd;
  logic [NW-1:0] node_addr;
  logic [127:0] node_wdata, node_rdata;
  logic [5:0]   lcp_out;

  logic        push, push_last;
  logic [2:0]  push_status;
  logic [4:0]  push_len;
  logic [31:0] push_asn, push_stamp;

  logic [7:0]  s;
  logic        accept, bad, full, idx_ok, out_free, l_match, stall;
  logic [31:0] cur_key, np, cur_links, cur_asn;
  logic [4:0]  nc, lim, common;
  logic [15:0] new1, new2;

  ipte_ram #(.WIDTH(96), .DEPTH(256)) u_slot_ram (
    .clk(clk), .we(slot_we), .addr(s), .wdata(slot_wdata), .rdata(slot_rdata)
  );

  ipte_ram #(.WIDTH(128), .DEPTH(POOL_NODES)) u_node_ram (
    .clk(clk), .we(node_we), .addr(node_addr), .wdata(node_wdata), .rdata(node_rdata)
  );

  ipte_lcp u_lcp (
    .diff({node_rdata[127:101], 5'b0} ^ a_q),
    .lead(lcp_out)
  );

  assign s         = a_q[31:24];
  assign slot_rd   = slot_vld[s] ? slot_rdata : 96'h0;
  assign in_ready  = (state == ipte_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign bad       = (prefix_len < ipte_pkg::LEN_MIN) || (prefix_len > ipte_pkg::LEN_MAX)
                     || (route_asn == 32'h0);
  assign full      = ({1'b0, nodes_used} + 17'd3) > POOL_LIM;
  assign idx_ok    = (idx_q != 16'h0) && ({1'b0, idx_q} < POOL_LIM);
  assign out_free  = !out_valid || out_ready;
  assign cur_key   = cur_q[127:96];
  assign cur_links = cur_q[95:64];
  assign cur_asn   = cur_q[63:32];
  assign nc        = cur_key[4:0];
  assign np        = {cur_key[31:5], 5'b0};
  assign lim       = (nc < len_q) ? nc : len_q;
  assign common    = (lcp_q < {1'b0, lim}) ? lcp_q[4:0] : lim;
  assign l_match   = lcp_q >= {1'b0, nc};
  assign stall     = l_match && (cur_asn != 32'h0) && pend_v && !out_free;
  assign new1      = nodes_used + 16'd1;
  assign new2      = nodes_used + 16'd2;

  always_comb begin
    state_next = state;
    unique case (state)
      ipte_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (req_type == ipte_pkg::REQ_INSERT && bad) ? ipte_pkg::ST_RES
                                                                 : ipte_pkg::ST_SLOT_RD;
        end
      end
      ipte_pkg::ST_SLOT_RD: state_next = ipte_pkg::ST_SLOT;
      ipte_pkg::ST_SLOT: begin
        if (req_q == ipte_pkg::REQ_INSERT && (len_q == ipte_pkg::LEN_MIN || full)) begin
          state_next = ipte_pkg::ST_RES;
        end else begin
          state_next = ipte_pkg::ST_CHECK;
        end
      end
      ipte_pkg::ST_CHECK: begin
        if (idx_ok) begin
          state_next = ipte_pkg::ST_NODE;
        end else begin
          state_next = (req_q == ipte_pkg::REQ_INSERT) ? ipte_pkg::ST_WR_N : ipte_pkg::ST_FIN;
        end
      end
      ipte_pkg::ST_NODE: state_next = ipte_pkg::ST_DEC;
      ipte_pkg::ST_DEC: begin
        if (req_q == ipte_pkg::REQ_INSERT) begin
          priority if (common < nc) begin
            state_next = (common != len_q) ? ipte_pkg::ST_WR_B : ipte_pkg::ST_WR_N;
          end else if (len_q == nc) begin
            state_next = ipte_pkg::ST_WR_ASN;
          end else begin
            state_next = ipte_pkg::ST_CHECK;
          end
        end else begin
          priority if (!l_match) begin
            state_next = ipte_pkg::ST_FIN;
          end else if (stall) begin
            state_next = ipte_pkg::ST_DEC;
          end else if (nc >= ipte_pkg::LEN_MAX) begin
            state_next = ipte_pkg::ST_FIN;
          end else begin
            state_next = ipte_pkg::ST_CHECK;
          end
        end
      end
      ipte_pkg::ST_WR_B:   state_next = ipte_pkg::ST_WR_N;
      ipte_pkg::ST_WR_N:   state_next = ipte_pkg::ST_WR_PAR;
      ipte_pkg::ST_WR_PAR: state_next = ipte_pkg::ST_RES;
      ipte_pkg::ST_WR_ASN: state_next = ipte_pkg::ST_RES;
      ipte_pkg::ST_RES, ipte_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = ipte_pkg::ST_IDLE;
        end
      end
      default: state_next = ipte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    slot_we     = 1'b0;
    slot_wdata  = {slot_rd[95:64], asn_q, stamp_q};
    node_we     = 1'b0;
    node_addr   = idx_q[NW-1:0];
    node_wdata  = {cur_q[127:64], asn_q, stamp_q};
    push        = 1'b0;
    push_status = ipte_pkg::STS_MATCH;
    push_len    = pend_len;
    push_asn    = pend_asn;
    push_stamp  = pend_stamp;
    push_last   = 1'b0;
    unique case (state)
      ipte_pkg::ST_SLOT: begin
        slot_we = (req_q == ipte_pkg::REQ_INSERT) && (len_q == ipte_pkg::LEN_MIN);
      end
      ipte_pkg::ST_DEC: begin
        push = (req_q == ipte_pkg::REQ_LOOKUP) && l_match && (cur_asn != 32'h0)
               && pend_v && out_free;
      end
      ipte_pkg::ST_WR_B: begin
        node_we    = 1'b1;
        node_addr  = new1[NW-1:0];
        node_wdata = {ipte_pkg::keep_top(a_q, common_q) | {27'h0, common_q},
                      ipte_pkg::bit_at(a_q, common_q) ? {new2, idx_q} : {idx_q, new2},
                      64'h0};
      end
      ipte_pkg::ST_WR_N: begin
        node_we    = 1'b1;
        node_addr  = new1[NW-1:0];
        node_wdata = {ipte_pkg::keep_top(a_q, len_q) | {27'h0, len_q},
                      above_q ? ipte_pkg::link_set(32'h0, ipte_pkg::bit_at(np, common_q), idx_q)
                              : 32'h0,
                      asn_q, stamp_q};
      end
      ipte_pkg::ST_WR_PAR: begin
        if (par_root_q) begin
          slot_we    = 1'b1;
          slot_wdata = {ipte_pkg::link_set(par_q[95:64], dir_q, child_q), par_q[63:0]};
        end else begin
          node_we    = 1'b1;
          node_addr  = par_idx_q[NW-1:0];
          node_wdata = {par_q[127:96], ipte_pkg::link_set(par_q[95:64], dir_q, child_q),
                        par_q[63:0]};
        end
      end
      ipte_pkg::ST_WR_ASN: begin
        node_we = 1'b1;
      end
      ipte_pkg::ST_RES: begin
        push        = out_free;
        push_status = res_q;
        push_len    = 5'h0;
        push_asn    = 32'h0;
        push_stamp  = 32'h0;
        push_last   = 1'b1;
      end
      ipte_pkg::ST_FIN: begin
        push      = out_free;
        push_last = 1'b1;
        if (!pend_v) begin
          push_status = ipte_pkg::STS_NO_MATCH;
          push_len    = 5'h0;
          push_asn    = 32'h0;
          push_stamp  = 32'h0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ipte_pkg::ST_IDLE;
      nodes_used <= 16'h0;
      routes     <= 17'h0;
      slot_vld   <= '0;
      out_valid  <= 1'b0;
      pend_v     <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ipte_pkg::ST_IDLE: begin
          pend_v <= 1'b0;
        end
        ipte_pkg::ST_SLOT: begin
          if (req_q == ipte_pkg::REQ_INSERT) begin
            if (len_q == ipte_pkg::LEN_MIN) begin
              slot_vld[s] <= 1'b1;
              if (slot_rd[63:32] == 32'h0) begin
                routes <= routes + 17'd1;
              end
            end
          end else if (slot_rd[63:32] != 32'h0) begin
            pend_v <= 1'b1;
          end
        end
        ipte_pkg::ST_DEC: begin
          if (req_q == ipte_pkg::REQ_LOOKUP && l_match && cur_asn != 32'h0 && !stall) begin
            pend_v <= 1'b1;
          end
        end
        ipte_pkg::ST_WR_B, ipte_pkg::ST_WR_N: begin
          nodes_used <= new1;
        end
        ipte_pkg::ST_WR_PAR: begin
          routes <= routes + 17'd1;
          if (par_root_q) begin
            slot_vld[s] <= 1'b1;
          end
        end
        ipte_pkg::ST_WR_ASN: begin
          if (cur_asn == 32'h0) begin
            routes <= routes + 17'd1;
          end
        end
        ipte_pkg::ST_FIN: begin
          if (out_free) begin
            pend_v <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      status      <= push_status;
      match_len   <= push_len;
      match_asn   <= push_asn;
      match_stamp <= push_stamp;
      route_count <= routes;
      last        <= push_last;
    end
    unique case (state)
      ipte_pkg::ST_IDLE: begin
        if (accept) begin
          req_q   <= req_type;
          a_q     <= (req_type == ipte_pkg::REQ_INSERT) ? ipte_pkg::keep_top(address, prefix_len)
                                                        : address;
          len_q   <= prefix_len;
          asn_q   <= route_asn;
          stamp_q <= stamp;
          res_q   <= ipte_pkg::STS_REJECTED;
        end
      end
      ipte_pkg::ST_SLOT: begin
        par_q      <= {32'h0, slot_rd};
        par_root_q <= 1'b1;
        dir_q      <= a_q[23];
        idx_q      <= ipte_pkg::link_of(slot_rd[95:64], a_q[23]);
        pend_len   <= ipte_pkg::LEN_MIN;
        pend_asn   <= slot_rd[63:32];
        pend_stamp <= slot_rd[31:0];
        if (len_q == ipte_pkg::LEN_MIN) begin
          res_q <= (slot_rd[63:32] == 32'h0) ? ipte_pkg::STS_NEW : ipte_pkg::STS_REPLACED;
        end else begin
          res_q <= ipte_pkg::STS_FULL;
        end
      end
      ipte_pkg::ST_CHECK: begin
        split_q <= 1'b0;
        above_q <= 1'b0;
      end
      ipte_pkg::ST_NODE: begin
        cur_q <= node_rdata;
        lcp_q <= lcp_out;
      end
      ipte_pkg::ST_DEC: begin
        common_q <= common;
        split_q  <= (common < nc) && (common != len_q);
        above_q  <= (common < nc) && (common == len_q);
        if (req_q == ipte_pkg::REQ_INSERT) begin
          if (common >= nc && len_q != nc) begin
            par_q      <= cur_q;
            par_root_q <= 1'b0;
            par_idx_q  <= idx_q;
            dir_q      <= ipte_pkg::bit_at(a_q, nc);
            idx_q      <= ipte_pkg::link_of(cur_links, ipte_pkg::bit_at(a_q, nc));
          end
        end else if (l_match && !stall) begin
          idx_q <= ipte_pkg::link_of(cur_links, ipte_pkg::bit_at(a_q, nc));
          if (cur_asn != 32'h0) begin
            pend_len   <= nc;
            pend_asn   <= cur_asn;
            pend_stamp <= cur_q[31:0];
          end
        end
      end
      ipte_pkg::ST_WR_B: begin
        child_q <= new1;
      end
      ipte_pkg::ST_WR_N: begin
        if (!split_q) begin
          child_q <= new1;
        end
      end
      ipte_pkg::ST_WR_PAR: begin
        res_q <= ipte_pkg::STS_NEW;
      end
      ipte_pkg::ST_WR_ASN: begin
        res_q <= (cur_asn == 32'h0) ? ipte_pkg::STS_NEW : ipte_pkg::STS_REPLACED;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, nodes_used} < POOL_LIM))
    else $error("node pool overrun");

  a_routes_step: assert property (@(posedge clk) disable iff (rst)
    (routes == $past(routes)) || (routes == $past(routes) + 17'd1))
    else $error("route count jumped");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(match_asn)))
    else $error("stalled result overwritten");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ipte_pkg::ST_IDLE && !accept) |=> !pend_v)
    else $error("match pending across requests");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(node_we && push))
    else $error("node write and result push in same cycle");
`endif

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int POOL = 256;

  typedef struct {
    ipte_pkg::status_t status;
    logic [4:0]  len;
    logic [31:0] asn;
    logic [31:0] stp;
    logic [16:0] count;
    logic        last;
  } route_result_t;

  class route_scoreboard;
    logic [31:0] slot_asn[256];
    logic [31:0] slot_stamp[256];
    logic [31:0] slot_links[256];
    logic [31:0] node_key[POOL];
    logic [31:0] node_links[POOL];
    logic [31:0] node_asn[POOL];
    logic [31:0] node_stamp[POOL];
    int unsigned nodes_used;
    logic [16:0] routes_held;
    route_result_t pending[$];
    int errors;

    function new();
      for (int i = 0; i < 256; i++) begin
        slot_asn[i] = 0;
        slot_stamp[i] = 0;
        slot_links[i] = 0;
      end
      nodes_used = 0;
      routes_held = 0;
      errors = 0;
    endfunction

    function logic [31:0] prefix_mask(logic [31:0] a, int len);
      if (len == 0) return 0;
      return a & (32'hFFFF_FFFF << (32 - len));
    endfunction

    function logic addr_bit(logic [31:0] a, int pos);
      return a[31 - pos];
    endfunction

    function logic [15:0] child(logic [31:0] links, logic dir);
      return dir ? links[31:16] : links[15:0];
    endfunction

    function logic [15:0] get_child(bit at_root, int at, logic dir);
      if (at_root) return child(slot_links[at], dir);
      return child(node_links[at], dir);
    endfunction

    function void set_child(bit at_root, int at, logic dir, logic [15:0] v);
      logic [31:0] l;
      l = at_root ? slot_links[at] : node_links[at];
      if (dir) l[31:16] = v;
      else l[15:0] = v;
      if (at_root) slot_links[at] = l;
      else node_links[at] = l;
    endfunction

    function int alloc_node(logic [31:0] a, int len, logic [31:0] asn, logic [31:0] st);
      nodes_used = nodes_used + 1;
      node_key[nodes_used] = prefix_mask(a, len) | len[4:0];
      node_links[nodes_used] = 0;
      node_asn[nodes_used] = asn;
      node_stamp[nodes_used] = st;
      return nodes_used;
    endfunction

    function ipte_pkg::status_t insert_route(logic [31:0] addr, int len, logic [31:0] asn,
                                             logic [31:0] st);
      logic [31:0] a, np, x;
      int s, at, idx, nc, lim, common, b, n;
      bit at_root;
      logic dir;
      ipte_pkg::status_t r;
      if (len < ipte_pkg::LEN_MIN || len > ipte_pkg::LEN_MAX || asn == 0)
        return ipte_pkg::STS_REJECTED;
      a = prefix_mask(addr, len);
      s = a[31:24];
      if (len == ipte_pkg::LEN_MIN) begin
        r = (slot_asn[s] == 0) ? ipte_pkg::STS_NEW : ipte_pkg::STS_REPLACED;
        if (r == ipte_pkg::STS_NEW) routes_held++;
        slot_asn[s] = asn;
        slot_stamp[s] = st;
        return r;
      end
      if (nodes_used + 3 > POOL) return ipte_pkg::STS_FULL;
      at_root = 1;
      at = s;
      dir = addr_bit(a, ipte_pkg::LEN_MIN);
      for (int k = 0; k < 24; k++) begin
        idx = get_child(at_root, at, dir);
        if (idx == 0) begin
          n = alloc_node(a, len, asn, st);
          set_child(at_root, at, dir, 16'(n));
          routes_held++;
          return ipte_pkg::STS_NEW;
        end
        nc = node_key[idx][4:0];
        np = node_key[idx] & ~32'd31;
        lim = nc < len ? nc : len;
        x = np ^ a;
        common = 0;
        while (common < 32 && !x[31 - common]) common++;
        if (common > lim) common = lim;
        if (common < nc) begin
          if (common == len) begin
            n = alloc_node(a, len, asn, st);
            set_child(0, n, addr_bit(np, common), 16'(idx));
            set_child(at_root, at, dir, 16'(n));
          end else begin
            b = alloc_node(a, common, 0, 0);
            set_child(0, b, addr_bit(np, common), 16'(idx));
            n = alloc_node(a, len, asn, st);
            set_child(0, b, addr_bit(a, common), 16'(n));
            set_child(at_root, at, dir, 16'(b));
          end
          routes_held++;
          return ipte_pkg::STS_NEW;
        end
        if (len == nc) begin
          r = (node_asn[idx] == 0) ? ipte_pkg::STS_NEW : ipte_pkg::STS_REPLACED;
          if (r == ipte_pkg::STS_NEW) routes_held++;
          node_asn[idx] = asn;
          node_stamp[idx] = st;
          return r;
        end
        at_root = 0;
        at = idx;
        dir = addr_bit(a, nc);
      end
      return ipte_pkg::STS_REJECTED;
    endfunction

    function void push(ipte_pkg::status_t st, int len, logic [31:0] asn, logic [31:0] stp);
      route_result_t e;
      e.status = st;
      e.len = 5'(len);
      e.asn = asn;
      e.stp = stp;
      e.count = routes_held;
      e.last = 0;
      pending.push_back(e);
    endfunction

    function void note_request(logic rtype, logic [31:0] addr, logic [4:0] len,
                               logic [31:0] asn, logic [31:0] st);
      int s, idx, nc, found;
      ipte_pkg::status_t r;
      if (rtype == ipte_pkg::REQ_INSERT) begin
        r = insert_route(addr, int'(len), asn, st);
        push(r, 0, 0, 0);
        pending[$].last = 1;
        return;
      end
      s = addr[31:24];
      found = 0;
      if (slot_asn[s] != 0) begin
        push(ipte_pkg::STS_MATCH, ipte_pkg::LEN_MIN, slot_asn[s], slot_stamp[s]);
        found++;
      end
      idx = child(slot_links[s], addr_bit(addr, ipte_pkg::LEN_MIN));
      for (int k = 0; k < 24 && idx != 0; k++) begin
        nc = node_key[idx][4:0];
        if (prefix_mask(addr, nc) != (node_key[idx] & ~32'd31)) break;
        if (node_asn[idx] != 0 && found < 17) begin
          push(ipte_pkg::STS_MATCH, nc, node_asn[idx], node_stamp[idx]);
          found++;
        end
        if (nc >= ipte_pkg::LEN_MAX) break;
        idx = child(node_links[idx], addr_bit(addr, nc));
      end
      if (found == 0) push(ipte_pkg::STS_NO_MATCH, 0, 0, 0);
      pending[$].last = 1;
    endfunction

    function void check_result(logic [2:0] st, logic [4:0] len, logic [31:0] asn,
                               logic [31:0] stp, logic [16:0] count, logic lst);
      route_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d len=%0d asn=%0h", st, len, asn);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status exp %0d got %0d", e.status, st); errors++;
      end
      if (len !== e.len) begin
        $error("match_len exp %0d got %0d", e.len, len); errors++;
      end
      if (asn !== e.asn) begin
        $error("match_asn exp %0h got %0h", e.asn, asn); errors++;
      end
      if (stp !== e.stp) begin
        $error("match_stamp exp %0h got %0h", e.stp, stp); errors++;
      end
      if (count !== e.count) begin
        $error("route_count exp %0d got %0d", e.count, count); errors++;
      end
      if (lst !== e.last) begin
        $error("last exp %0d got %0d", e.last, lst); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic        req_type = 0;
  logic [31:0] address = 0;
  logic [4:0]  prefix_len = 0;
  logic [31:0] route_asn = 0;
  logic [31:0] stamp = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  status;
  logic [4:0]  match_len;
  logic [31:0] match_asn;
  logic [31:0] match_stamp;
  logic [16:0] route_count;
  logic        last;

  route_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  logic [31:0] seeds[4];

  ipv4_prefix_trie_engine #(.POOL_NODES(POOL)) dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(status, match_len, match_asn, match_stamp, route_count, last);
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send(logic t, logic [31:0] a, logic [4:0] l, logic [31:0] asn,
                      logic [31:0] st);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    req_type <= t;
    address <= a;
    prefix_len <= l;
    route_asn <= asn;
    stamp <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(t, a, l, asn, st);
  endtask

  function automatic logic [31:0] near_seed();
    logic [31:0] a;
    a = seeds[$urandom_range(3)];
    if ($urandom_range(3) == 0) a[31 - $urandom_range(9, 23)] ^= 1'b1;
    if ($urandom_range(3) == 0) a[31 - $urandom_range(9, 23)] ^= 1'b1;
    return a ^ ($urandom() & 32'h0000_00FF);
  endfunction

  task automatic random_request();
    logic [31:0] a;
    int l;
    if ($urandom_range(9) == 0) a = $urandom();
    else a = near_seed();
    if ($urandom_range(99) < 55) begin
      l = $urandom_range(19) == 0 ? $urandom_range(31) : $urandom_range(8, 24);
      send(ipte_pkg::REQ_INSERT, a, 5'(l), $urandom_range(15) == 0 ? 32'd0 : $urandom(),
           $urandom());
    end else begin
      send(ipte_pkg::REQ_LOOKUP, a, 5'($urandom()), $urandom(), $urandom());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(ipte_pkg::REQ_INSERT, 32'h0A00_0000, 8, 1, 32'h11);
    send(ipte_pkg::REQ_INSERT, 32'h0A12_3456, 8, 2, 32'h22);
    send(ipte_pkg::REQ_INSERT, 32'h0A01_0203, 24, 3, 32'h33);
    send(ipte_pkg::REQ_INSERT, 32'h0A01_0000, 16, 4, 32'h44);
    send(ipte_pkg::REQ_INSERT, 32'h0A01_0300, 24, 5, 32'h55);
    send(ipte_pkg::REQ_INSERT, 32'h0A01_0200, 23, 6, 32'h66);
    send(ipte_pkg::REQ_INSERT, 32'h0A01_0200, 23, 7, 32'h77);
    send(ipte_pkg::REQ_INSERT, 32'h0A01_8000, 17, 8, 32'h88);
    send(ipte_pkg::REQ_INSERT, 32'h0A00_0000, 7, 9, 0);
    send(ipte_pkg::REQ_INSERT, 32'h0A00_0000, 25, 9, 0);
    send(ipte_pkg::REQ_INSERT, 32'h0A00_0000, 31, 9, 0);
    send(ipte_pkg::REQ_INSERT, 32'h0A00_0000, 0, 9, 0);
    send(ipte_pkg::REQ_INSERT, 32'h0A02_0000, 16, 0, 1);
    send(ipte_pkg::REQ_INSERT, 32'hFFFF_FFFF, 24, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ipte_pkg::REQ_INSERT, 32'hFFFF_FFFF, 8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ipte_pkg::REQ_INSERT, 32'h0000_0000, 9, 10, 0);
    send(ipte_pkg::REQ_LOOKUP, 32'h0A01_024D, 0, 0, 0);
    send(ipte_pkg::REQ_LOOKUP, 32'h0A01_0301, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ipte_pkg::REQ_LOOKUP, 32'h0B00_0000, 0, 0, 0);
    send(ipte_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 31, 5, 5);
    send(ipte_pkg::REQ_LOOKUP, 32'h0000_0001, 0, 0, 0);
    send(ipte_pkg::REQ_LOOKUP, 32'h0A80_0000, 0, 0, 0);

    for (int i = 0; i < 4; i++) seeds[i] = $urandom();
    seeds[0][31:24] = 8'h0A;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 75 : 34) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 75 : 34) : 0;
      for (int i = 0; i < 82; i++) begin
        if ($urandom_range(39) == 0) seeds[$urandom_range(3)] = $urandom();
        random_request();
      end
    end
    in_valid <= 0;
    idle_pct = 0;
    stall_pct = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- ipv4_prefix_trie_engine.f -----
rtl/core/ipte_pkg.sv
rtl/core/ipte_ram.sv
rtl/core/ipte_lcp.sv
rtl/core/ipv4_prefix_trie_engine.sv
bench/tb_top.sv
